[rtl/core/adrp_pkg.sv]
package adrp_pkg;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 64;
  localparam int REG_W   = 5;
  localparam int COUNT_W = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // opcode marks
  localparam logic [4:0] ADR_MARK   = 5'b10000;
  localparam logic [7:0] LDR_MARK_A = 8'b11100001;
  localparam logic [7:0] LDR_MARK_B = 8'b11100101;

  localparam logic [COUNT_W-1:0] WINDOW_RESET = 7'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;

  // register index (paddr word select)
  localparam logic REG_WINDOW = 1'b0;

  // decoded item queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic              first;
    logic              is_adr;
    logic [REG_W-1:0]  adr_reg;
    logic [ADDR_W-1:0] adr_target;
    logic              is_ldr;
    logic [REG_W-1:0]  ldr_rn;
    logic [ADDR_W-1:0] ldr_off;
  } dec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/core/adrp_if.sv]
interface adrp_in_if;
  logic                        valid;
  logic                        ready;
  logic [adrp_pkg::WORD_W-1:0] instr_word;
  logic [adrp_pkg::ADDR_W-1:0] instr_addr;
  logic                        first_word;

  modport source(output valid, instr_word, instr_addr, first_word, input ready);
  modport sink(input valid, instr_word, instr_addr, first_word, output ready);
endinterface

interface adrp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [adrp_pkg::ADDR_W-1:0] resolved_addr;
  logic                        search_done;

  modport source(output valid, found, resolved_addr, search_done, input ready);
  modport sink(input valid, found, resolved_addr, search_done, output ready);
endinterface

[rtl/core/adrp_front.sv]
module adrp_front (
  adrp_in_if.sink               in_ch,
  input  adrp_pkg::queue_status_t q_status,
  output logic                  push,
  output adrp_pkg::dec_t        push_rec
);
  import adrp_pkg::*;

  logic [WORD_W-1:0] w;
  logic [ADDR_W-1:0] pc;
  logic [7:0]        ldr_sel;
  logic              unsig;
  logic [20:0]       imm21;
  logic [ADDR_W-1:0] imm_sext;
  logic [ADDR_W-1:0] scaled_off;

  assign w  = in_ch.instr_word;
  assign pc = in_ch.instr_addr;

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  always_comb begin
    ldr_sel    = w[29:22];
    unsig      = w[24];
    imm21      = {w[23:5], w[30:29]};
    imm_sext   = {{(ADDR_W-21){imm21[20]}}, imm21};
    scaled_off = {{(ADDR_W-12){1'b0}}, w[21:10]} << w[31:30];

    push_rec.first  = in_ch.first_word;
    push_rec.is_adr = (w[28:24] == ADR_MARK);
    push_rec.adr_reg = w[4:0];
    if (w[31]) begin
      // adrp: 4 KiB page of pc plus page offset
      push_rec.adr_target = {pc[ADDR_W-1:12], 12'b0} + {imm_sext[ADDR_W-13:0], 12'b0};
    end else begin
      push_rec.adr_target = pc + imm_sext;
    end
    // register-offset form is not an immediate load
    push_rec.is_ldr = ((ldr_sel == LDR_MARK_A) || (ldr_sel == LDR_MARK_B)) &&
                      !(!unsig && w[21]);
    push_rec.ldr_rn = w[9:5];
    if (unsig) begin
      push_rec.ldr_off = scaled_off;
    end else begin
      push_rec.ldr_off = {{(ADDR_W-9){w[20]}}, w[20:12]};
    end
  end

endmodule

[rtl/core/adrp_queue.sv]
module adrp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  adrp_pkg::dec_t          push_rec,
  input  logic                    pop,
  output adrp_pkg::queue_status_t q_status,
  output adrp_pkg::dec_t          head_rec
);
  import adrp_pkg::*;

  dec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign head_rec       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/adrp_back.sv]
module adrp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [adrp_pkg::COUNT_W-1:0]    window,
  input  adrp_pkg::queue_status_t         q_status,
  input  adrp_pkg::dec_t                  head_rec,
  output logic                            pop,
  adrp_out_if.source                      out_ch
);
  import adrp_pkg::*;

  // search state
  logic               held_valid;
  logic [REG_W-1:0]   held_reg;
  logic [ADDR_W-1:0]  held_target;
  logic [COUNT_W-1:0] words_seen;
  logic               finished;

  logic               held_valid_next;
  logic [REG_W-1:0]   held_reg_next;
  logic [ADDR_W-1:0]  held_target_next;
  logic [COUNT_W-1:0] words_seen_next;
  logic               finished_next;

  // output register
  logic               out_valid;
  logic               found;
  logic [ADDR_W-1:0]  resolved_addr;
  logic               search_done;
  logic               found_next;
  logic [ADDR_W-1:0]  resolved_addr_next;

  logic               hv;
  logic [COUNT_W-1:0] ws;
  logic               fin;

  assign pop = !q_status.empty && (!out_valid || out_ch.ready);

  assign out_ch.valid         = out_valid;
  assign out_ch.found         = found;
  assign out_ch.resolved_addr = resolved_addr;
  assign out_ch.search_done   = search_done;

  always_comb begin
    // first word clears the search before the word is used
    hv  = held_valid && !head_rec.first;
    ws  = head_rec.first ? '0 : words_seen;
    fin = finished && !head_rec.first;

    held_valid_next    = hv;
    held_reg_next      = held_reg;
    held_target_next   = held_target;
    words_seen_next    = ws;
    finished_next      = fin;
    found_next         = 1'b0;
    resolved_addr_next = '0;

    if (!fin) begin
      if (head_rec.is_ldr && hv && (head_rec.ldr_rn == held_reg)) begin
        found_next         = 1'b1;
        resolved_addr_next = held_target + head_rec.ldr_off;
        finished_next      = 1'b1;
      end
      if (head_rec.is_adr && (ws < window)) begin
        held_valid_next  = 1'b1;
        held_reg_next    = head_rec.adr_reg;
        held_target_next = head_rec.adr_target;
      end else begin
        held_valid_next = 1'b0;
      end
      if (ws >= window) begin
        finished_next = 1'b1;
      end
      if (ws < COUNT_MAX) begin
        words_seen_next = ws + 1'b1;
      end
      if (finished_next) begin
        held_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      words_seen <= '0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        held_valid <= held_valid_next;
        words_seen <= words_seen_next;
        finished   <= finished_next;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held_reg      <= held_reg_next;
      held_target   <= held_target_next;
      found         <= found_next;
      resolved_addr <= resolved_addr_next;
      search_done   <= finished_next;
    end
  end

endmodule

[rtl/core/adrp_ldr_pair_address_finder.sv]
// adr/adrp + ldr pair address finder
// an accepted item is decoded into the queue, then its search state update is
//   registered into the output register
// throughput: one item per cycle unless the output stalls, set by the back-end update
// reset (rst, synchronous): search state cleared, queue and output emptied, window = 10
module adrp_ldr_pair_address_finder (
  input  logic                             clk,
  input  logic                             rst,
  adrp_in_if.sink                          in_ch,
  adrp_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [adrp_pkg::PADDR_W-1:0]     paddr,
  input  logic [adrp_pkg::PDATA_W-1:0]     pwdata,
  output logic [adrp_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import adrp_pkg::*;

  // configuration register
  logic [COUNT_W-1:0] window;
  logic               cfg_write;

  // front to queue
  logic               push;
  dec_t               push_rec;
  // queue to back
  queue_status_t      q_status;
  dec_t               head_rec;
  logic               pop;

  // apb: always ready, write at the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_write && (paddr[PADDR_W-1] == REG_WINDOW)) begin
      window <= pwdata[COUNT_W-1:0];
    end
  end

  // read back; addresses beyond the register read as zero
  always_comb begin
    if (paddr[PADDR_W-1] == REG_WINDOW) begin
      prdata = {{(PDATA_W-COUNT_W){1'b0}}, window};
    end else begin
      prdata = '0;
    end
  end

  // front end: decode adr/adrp target and ldr offset, independent of search state
  adrp_front u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_rec (push_rec)
  );

  // two-entry queue decouples input acceptance from output stalls
  adrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .q_status (q_status),
    .head_rec (head_rec)
  );

  // back end: match against the held decode, window count, output register
  adrp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .window   (window),
    .q_status (q_status),
    .head_rec (head_rec),
    .pop      (pop),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // a match always ends the search
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.found) |-> out_ch.search_done)
    else $error("found without search_done");

  // no match means a zero address
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.found) |-> (out_ch.resolved_addr == '0))
    else $error("nonzero address without match");

  // reset loads the default window
  a_window_reset: assert property (@(posedge clk)
    rst |=> (window == WINDOW_RESET))
    else $error("window not reset");

  // input is refused only while the queue is full
  a_ready_queue: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == !q_status.full)
    else $error("ready does not follow queue level");
`endif

endmodule

[tb/adrp_ldr_pair_address_finder_checker.sv]
`timescale 1ns / 100ps
module adrp_ldr_pair_address_finder_checker (
  input  logic                         clk,
  input  logic                         rst,
  adrp_in_if                           in_mon,
  adrp_out_if                          out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adrp_pkg::PADDR_W-1:0] paddr,
  input  logic [adrp_pkg::PDATA_W-1:0] pwdata,
  input  logic [adrp_pkg::PDATA_W-1:0] prdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           results_due,
  output int                           results_checked,
  output int                           hits_seen
);
  import adrp_pkg::*;

  localparam int MAX_REPORTS = 25;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic              done;
  } lookup_t;

  lookup_t            lookups_due[$];
  logic [COUNT_W-1:0] window_len;
  logic               pair_armed;
  logic [REG_W-1:0]   pair_reg;
  logic [ADDR_W-1:0]  pair_target;
  logic [COUNT_W-1:0] word_count;
  logic               search_over;

  function automatic void clear_search();
    pair_armed  = 1'b0;
    pair_reg    = '0;
    pair_target = '0;
    word_count  = '0;
    search_over = 1'b0;
  endfunction

  // advance the search by one word and return the lookup it yields
  function automatic lookup_t resolve_word(logic [WORD_W-1:0] w, logic [ADDR_W-1:0] pc,
                                           logic first);
    lookup_t           r;
    logic              load_hit;
    logic [20:0]       imm21;
    logic [ADDR_W-1:0] disp;
    logic [ADDR_W-1:0] off;
    r = '0;
    if (first) clear_search();
    if (!search_over) begin
      load_hit = (w[29:22] == LDR_MARK_A) || (w[29:22] == LDR_MARK_B);
      // register-offset load is not an immediate load
      if (load_hit && !w[24] && w[21]) load_hit = 1'b0;
      if (load_hit && pair_armed && w[9:5] == pair_reg) begin
        if (w[24]) off = ADDR_W'(w[21:10]) << w[31:30];
        else off = {{(ADDR_W-9){w[20]}}, w[20:12]};
        r.found     = 1'b1;
        r.addr      = pair_target + off;
        search_over = 1'b1;
      end
      if (w[28:24] == ADR_MARK && word_count < window_len) begin
        imm21      = {w[23:5], w[30:29]};
        disp       = {{(ADDR_W-21){imm21[20]}}, imm21};
        pair_armed = 1'b1;
        pair_reg   = w[4:0];
        if (w[31]) pair_target = {pc[ADDR_W-1:12], 12'h000} + (disp << 12);
        else pair_target = pc + disp;
      end else begin
        pair_armed = 1'b0;
      end
      if (word_count >= window_len) search_over = 1'b1;
      if (word_count < COUNT_MAX) word_count = word_count + 1'b1;
      if (search_over) pair_armed = 1'b0;
    end
    r.done = search_over;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    if (rst) begin
      window_len = WINDOW_RESET;
      clear_search();
      lookups_due.delete();
      results_due     = 0;
      fail_count      = 0;
      results_checked = 0;
      hits_seen       = 0;
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_WINDOW) begin
        if (pwrite) begin
          window_len = pwdata[COUNT_W-1:0];
        end else if (prdata != PDATA_W'(window_len)) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t window readback: expected %0d, got %0d", $time, window_len, prdata);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (lookups_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t unexpected result: expected none, got found=%0b addr=%h done=%0b",
                     $time, out_mon.found, out_mon.resolved_addr, out_mon.search_done);
        end else begin
          want = lookups_due.pop_front();
          results_checked++;
          if (want.found != out_mon.found || want.addr != out_mon.resolved_addr ||
              want.done != out_mon.search_done) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t mismatch: expected %0b/%h/%0b, got %0b/%h/%0b (found/addr/done)",
                       $time, want.found, want.addr, want.done,
                       out_mon.found, out_mon.resolved_addr, out_mon.search_done);
          end else if (want.found) begin
            hits_seen++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        lookups_due.push_back(resolve_word(in_mon.instr_word, in_mon.instr_addr,
                                           in_mon.first_word));
      results_due = lookups_due.size();
    end
  end

endmodule

[tb/adrp_ldr_pair_address_finder_tb.sv]
`timescale 1ns / 100ps
module adrp_ldr_pair_address_finder_tb;
  import adrp_pkg::*;

  localparam int                  PHASE_ITEMS = 110;
  localparam int                  DRAIN_LIMIT = 20000;
  localparam logic [WORD_W-1:0]   NOP_WORD    = 32'hD503201F;
  localparam logic [PADDR_W-1:0]  WINDOW_ADDR = PADDR_W'({REG_WINDOW, 2'b00});

  // load encodings exercised by the stimulus
  typedef enum int {LD_UNSIGNED, LD_INDEXED, LD_REGOFF} ld_form_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int results_due;
  int results_checked;
  int hits_seen;
  int words_sent;
  int settings_used;
  int ready_left;
  bit calm;

  adrp_in_if  in_ch();
  adrp_out_if out_ch();

  adrp_ldr_pair_address_finder dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicts every lookup and compares it against the output channel
  adrp_ldr_pair_address_finder_checker watcher (
    .clk             (clk),
    .rst             (rst),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .results_due     (results_due),
    .results_checked (results_checked),
    .hits_seen       (hits_seen)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(10_000_000);
    $display("adrp_ldr_pair_address_finder verification failed");
    $finish;
  end

  // result backpressure: ready stretches, now and then long, broken by stalls, mostly short
  initial begin : sink_pacing
    int r;
    out_ch.ready = 1'b0;
    ready_left   = 0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (ready_left > 0) begin
        ready_left--;
      end else if (out_ch.ready) begin
        out_ch.ready = 1'b0;
        ready_left   = (r < 80) ? $urandom_range(0, 2) : $urandom_range(5, 40);
      end else begin
        out_ch.ready = 1'b1;
        ready_left   = (r < 10) ? $urandom_range(50, 150) : $urandom_range(0, 12);
      end
    end
  end

  // adr / adrp: op, immlo, mark, immhi, rd
  function automatic logic [WORD_W-1:0] enc_adr(logic page, logic [REG_W-1:0] rd,
                                                logic [20:0] imm);
    return {page, imm[1:0], ADR_MARK, imm[20:2], rd};
  endfunction

  // integer ldr, immediate or register-offset form
  function automatic logic [WORD_W-1:0] enc_ldr(ld_form_t form, logic [1:0] size,
                                                logic [REG_W-1:0] rn, logic [11:0] imm,
                                                logic [1:0] idx, logic [REG_W-1:0] rt);
    case (form)
      LD_UNSIGNED: return {size, LDR_MARK_B, imm, rn, rt};
      LD_INDEXED:  return {size, LDR_MARK_A, 1'b0, imm[8:0], idx, rn, rt};
      default:     return {size, LDR_MARK_A, 1'b1, imm[8:0], idx, rn, rt};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_ldr(logic [REG_W-1:0] rn);
    int       r;
    ld_form_t form;
    r = $urandom_range(0, 99);
    if (r < 45) form = LD_UNSIGNED;
    else if (r < 90) form = LD_INDEXED;
    else form = LD_REGOFF;
    return enc_ldr(form, 2'($urandom), rn, 12'($urandom), 2'($urandom), REG_W'($urandom));
  endfunction

  // sender gap: mostly none, some short, a few long; none at all in calm searches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // one item on the input channel; returns at the falling edge after acceptance
  task automatic send_word(logic [WORD_W-1:0] w, logic [ADDR_W-1:0] pc, logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.instr_word = w;
    in_ch.instr_addr = pc;
    in_ch.first_word = first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
  endtask

  // hold off the sender until every predicted result has come back
  task automatic await_quiet();
    in_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // apb setup then access phase
  task automatic apb_access(logic wr, logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = WINDOW_ADDR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // new window length, written and read back while the block is idle
  task automatic set_window(logic [COUNT_W-1:0] len);
    await_quiet();
    apb_access(1'b1, PDATA_W'(len));
    apb_access(1'b0, '0);
    settings_used++;
  endtask

  // one search: mostly an adr/adrp followed by a load off the same register,
  // with filler in front, sometimes broken up, sometimes pure noise
  task automatic run_search(int win);
    logic [ADDR_W-1:0] pc;
    logic [REG_W-1:0]  rd;
    int                r;
    int                lead;
    int                lead_max;
    calm = ($urandom_range(0, 7) == 0);
    pc   = {$urandom, $urandom};
    r    = $urandom_range(0, 99);
    // pages at the very top and bottom of memory for wraparound
    if (r < 4) pc[ADDR_W-1:16] = '1;
    else if (r < 8) pc[ADDR_W-1:16] = '0;
    r = $urandom_range(0, 99);
    if (r >= 85) begin
      // noise, with random search starts
      repeat ($urandom_range(1, 8)) begin
        send_word($urandom, pc, $urandom_range(0, 3) == 0);
        pc = pc + 4;
      end
    end else begin
      lead_max = (win > 4) ? 3 : ((win > 0) ? win - 1 : 0);
      // now and then push the pair to or past the end of the window
      if (r < 5) lead = $urandom_range(0, (win < 129) ? win + 1 : 130);
      else lead = $urandom_range(0, lead_max);
      rd = REG_W'($urandom);
      for (int i = 0; i < lead; i++) begin
        send_word($urandom, pc, i == 0);
        pc = pc + 4;
      end
      send_word(enc_adr(1'($urandom), rd, 21'($urandom)), pc, lead == 0);
      pc = pc + 4;
      // a word between the two breaks the pair
      if ($urandom_range(0, 9) == 0) begin
        send_word($urandom, pc, 1'b0);
        pc = pc + 4;
      end
      send_word(rand_ldr(($urandom_range(0, 5) == 0) ? REG_W'($urandom) : rd), pc, 1'b0);
      pc = pc + 4;
      // trailing words; after a matching load they land once the search has ended
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 2)) begin
          send_word($urandom, pc, 1'b0);
          pc = pc + 4;
        end
      end
    end
  endtask

  initial begin : stimulus
    int                windows[9];
    int                win;
    int                budget;
    int                drain;
    logic [ADDR_W-1:0] base;
    windows = '{64, 1, 10, 127, 2, 0, -1, -1, 64};
    // every input known from time zero
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.instr_word = '0;
    in_ch.instr_addr = '0;
    in_ch.first_word = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    words_sent       = 0;
    settings_used    = 0;
    calm             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset window length
    base = 64'h0000_0000_0040_1000;
    // no search ever started: words run against the reset state
    send_word(enc_adr(1'b1, 5'd3, 21'h000001), base, 1'b0);
    send_word(enc_ldr(LD_UNSIGNED, 2'b11, 5'd3, 12'hFFF, 2'b00, 5'd1), base + 4, 1'b0);
    // ignored once the search is over
    send_word(NOP_WORD, base + 8, 1'b0);
    // largest forward adr from the top of memory, most negative unscaled offset
    send_word(enc_adr(1'b0, 5'd0, 21'h0FFFFF), '1, 1'b1);
    send_word(enc_ldr(LD_INDEXED, 2'b00, 5'd0, 12'h100, 2'b00, 5'd2), '0, 1'b0);
    // most negative adr from address zero, post-index with largest offset
    send_word(enc_adr(1'b0, 5'd31, 21'h100000), '0, 1'b1);
    send_word(enc_ldr(LD_INDEXED, 2'b01, 5'd31, 12'h0FF, 2'b01, 5'd0), 64'd4, 1'b0);
    // adrp one page back, unaligned pc, zero unsigned offset
    send_word(enc_adr(1'b1, 5'd31, 21'h1FFFFF), 64'hFFFF_FFFF_FFFF_F123, 1'b1);
    send_word(enc_ldr(LD_UNSIGNED, 2'b00, 5'd31, 12'h000, 2'b00, 5'd31),
              64'hFFFF_FFFF_FFFF_F127, 1'b0);
    // register-offset load does not complete a pair and clears the held decode
    send_word(enc_adr(1'b1, 5'd5, 21'h000010), base, 1'b1);
    send_word(enc_ldr(LD_REGOFF, 2'b10, 5'd5, 12'h0AA, 2'b10, 5'd6), base + 4, 1'b0);
    send_word(enc_ldr(LD_UNSIGNED, 2'b10, 5'd5, 12'h004, 2'b00, 5'd6), base + 8, 1'b0);
    // base register mismatch, pre-index form
    send_word(enc_adr(1'b1, 5'd7, 21'h0ABCDE), base, 1'b1);
    send_word(enc_ldr(LD_INDEXED, 2'b11, 5'd8, 12'h0F0, 2'b11, 5'd7), base + 4, 1'b0);
    // second adr replaces the first
    send_word(enc_adr(1'b0, 5'd2, 21'h000123), base, 1'b1);
    send_word(enc_adr(1'b0, 5'd4, 21'h000456), base + 4, 1'b0);
    send_word(enc_ldr(LD_UNSIGNED, 2'b01, 5'd2, 12'h800, 2'b00, 5'd0), base + 8, 1'b0);
    // word in between breaks the pair
    send_word(enc_adr(1'b1, 5'd9, 21'h000002), base, 1'b1);
    send_word(NOP_WORD, base + 4, 1'b0);
    send_word(enc_ldr(LD_UNSIGNED, 2'b11, 5'd9, 12'h001, 2'b00, 5'd0), base + 8, 1'b0);
    // zero window: done at word zero, nothing held
    set_window(7'd0);
    send_word(enc_adr(1'b1, 5'd1, 21'h000001), base, 1'b1);
    send_word(enc_ldr(LD_UNSIGNED, 2'b10, 5'd1, 12'h010, 2'b00, 5'd0), base + 4, 1'b0);
    // one-pair window: a pair at word zero matches, an adr at word one is not held
    set_window(7'd1);
    send_word(enc_adr(1'b1, 5'd1, 21'h000003), base, 1'b1);
    send_word(enc_ldr(LD_UNSIGNED, 2'b10, 5'd1, 12'h010, 2'b00, 5'd0), base + 4, 1'b0);
    send_word(NOP_WORD, base, 1'b1);
    send_word(enc_adr(1'b1, 5'd6, 21'h000003), base + 4, 1'b0);
    send_word(enc_ldr(LD_UNSIGNED, 2'b00, 5'd6, 12'h010, 2'b00, 5'd0), base + 8, 1'b0);

    // random phases across window lengths, extremes included
    foreach (windows[p]) begin
      win = (windows[p] < 0) ? $urandom_range(1, 64) : windows[p];
      set_window(COUNT_W'(win));
      budget = words_sent + ((win == 0) ? 30 : PHASE_ITEMS);
      while (words_sent < budget) run_search(win);
    end

    // drain, then let the pipeline idle before the report
    in_ch.valid = 1'b0;
    drain       = 0;
    while (results_due != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(negedge clk);

    $display("sent %0d words over %0d window settings, checked %0d results, %0d resolved loads",
             words_sent, settings_used, results_checked, hits_seen);
    if (results_due != 0) $display("%0d expected results never arrived", results_due);
    if (fail_count == 0 && results_due == 0) begin
      $display("adrp_ldr_pair_address_finder verification clean");
    end else begin
      $display("adrp_ldr_pair_address_finder verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/adrp_pkg.sv
rtl/core/adrp_if.sv
rtl/core/adrp_front.sv
rtl/core/adrp_queue.sv
rtl/core/adrp_back.sv
rtl/core/adrp_ldr_pair_address_finder.sv
tb/adrp_ldr_pair_address_finder_checker.sv
tb/adrp_ldr_pair_address_finder_tb.sv
